/* src/tcrb_pkg.sv */
// Package for the text cell ring buffer: opcodes, register indexes,
// character codes and reset defaults. No dependencies.
package tcrb_pkg;

  localparam int unsigned MaxCellsDefault = 8192;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CellW   = 32;

  typedef enum logic [2:0] {
    OP_PUT    = 3'd0,
    OP_GET    = 3'd1,
    OP_UNGET  = 3'd2,
    OP_FILL   = 3'd3,
    OP_CURSOR = 3'd4
  } opcode_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ROWS  = 3'd0,
    CFG_COLS  = 3'd1,
    CFG_FG    = 3'd2,
    CFG_BG    = 3'd3,
    CFG_FONT  = 3'd4
  } cfg_idx_e;

  localparam logic [7:0] ChBackspace = 8'h08;
  localparam logic [7:0] ChNewline   = 8'h0a;

  localparam logic [6:0] RowsReset = 7'd25;
  localparam logic [7:0] ColsReset = 8'd80;
  localparam logic [7:0] FgReset   = 8'd7;
  localparam logic [7:0] BgReset   = 8'd0;
  localparam logic [7:0] FontReset = 8'd0;

endpackage

/* src/text_cell_ring_buffer.sv */
// Text cell ring buffer: a cell memory with write and read positions; depends on tcrb_pkg.
// Put, backspace and unknown opcodes finish in the execute state; get and unget, when they
// succeed, add a memory read state; newline and set cursor run a divider for the remainder
// (one remainder bit per cycle) and then a post state; fill writes T cells, T = min(rows*cols,
// MAX_CELLS) with zero counts taken as one. A new command is taken in the cycle of the strobe;
// the receiver cannot stall. After reset the memory is cleared with busy_o high.
module text_cell_ring_buffer
  import tcrb_pkg::*;
#(
  parameter int unsigned MAX_CELLS = MaxCellsDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [2:0]         opcode_i,
  input  logic [7:0]         char_in_i,
  input  logic [5:0]         cursor_row_i,
  input  logic [6:0]         cursor_col_i,
  output logic               done_o,
  output logic [7:0]         char_out_o,
  output logic               ok_o,
  output logic               empty_res_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [7:0]         cfg_data_i
);

  localparam int unsigned PW   = $clog2(MAX_CELLS);
  localparam int unsigned TW   = PW + 1;
  localparam int unsigned MW   = (TW > 15) ? TW : 15;
  localparam int unsigned DSW  = (TW > 8) ? TW : 8;
  localparam int unsigned DVW  = (PW > 14) ? PW : 14;
  localparam int unsigned CNTW = $clog2(DVW + 1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_GET,
    S_UNGET,
    S_FILL,
    S_DIV,
    S_POST
  } state_e;

  state_e          state_q, state_d;
  logic [6:0]      rows_q, rows_d;
  logic [7:0]      cols_q, cols_d;
  logic [7:0]      fg_q, fg_d;
  logic [7:0]      bg_q, bg_d;
  logic [7:0]      font_q, font_d;
  logic [PW-1:0]   wp_q, wp_d;
  logic [PW-1:0]   rp_q, rp_d;
  logic [PW-1:0]   cnt_q, cnt_d;
  logic [CNTW-1:0] div_cnt_q, div_cnt_d;
  logic            done_q, done_d;
  logic [7:0]      char_out_q, char_out_d;
  logic            ok_q, ok_d;
  logic            empty_q, empty_d;

  logic [2:0]      op_q;
  logic [7:0]      ch_q;
  logic [5:0]      row_q;
  logic [6:0]      col_q;
  logic [TW-1:0]   total_q;
  logic [DSW-1:0]  div_rem_q;
  logic [DVW-1:0]  div_dvd_q;
  logic [DSW-1:0]  div_dvs_q;

  logic [CellW-1:0] mem [MAX_CELLS];
  logic [CellW-1:0] rdata_q;
  logic             mem_we;
  logic [PW-1:0]    mem_waddr;
  logic [CellW-1:0] mem_wdata;
  logic [PW-1:0]    mem_raddr;

  logic             accept;
  logic [6:0]       rows_eff;
  logic [7:0]       cols_eff;
  logic [MW-1:0]    prod;
  logic [TW-1:0]    total_in;
  logic [PW:0]      wp_inc;
  logic [PW:0]      rp_inc;
  logic [PW-1:0]    last_pos;
  logic [PW-1:0]    unget_pos;
  logic [13:0]      cursor_lin;
  logic             div_load;
  logic [DVW-1:0]   div_dvd_in;
  logic [DSW-1:0]   div_dvs_in;
  logic [DSW:0]     rem_sh;
  logic [DSW-1:0]   rem_nx;
  logic [DSW:0]     lf_pos;
  logic [CellW-1:0] new_cell;

  assign busy_o      = (state_q != S_IDLE);
  assign accept      = start_i && !busy_o;
  assign cfg_ready_o = 1'b1;
  assign done_o      = done_q;
  assign char_out_o  = char_out_q;
  assign ok_o        = ok_q;
  assign empty_res_o = empty_q;

  assign rows_eff = (rows_q == 7'd0) ? 7'd1 : rows_q;
  assign cols_eff = (cols_q == 8'd0) ? 8'd1 : cols_q;
  assign prod     = MW'(rows_eff) * MW'(cols_eff);
  assign total_in = (prod > MW'(MAX_CELLS)) ? TW'(MAX_CELLS) : TW'(prod);

  assign wp_inc     = (PW + 1)'(wp_q) + (PW + 1)'(1);
  assign rp_inc     = (PW + 1)'(rp_q) + (PW + 1)'(1);
  assign last_pos   = PW'(total_q - TW'(1));
  assign unget_pos  = (rp_q == '0) ? last_pos : rp_q - PW'(1);
  assign cursor_lin = 14'(row_q) * 14'(cols_eff) + 14'(col_q);
  assign new_cell   = {font_q, bg_q, fg_q, ch_q};

  assign rem_sh = {div_rem_q, div_dvd_q[DVW-1]};
  assign rem_nx = (rem_sh >= {1'b0, div_dvs_q}) ? DSW'(rem_sh - {1'b0, div_dvs_q})
                                                : DSW'(rem_sh);
  assign lf_pos = (DSW + 1)'(wp_q) - (DSW + 1)'(div_rem_q) + (DSW + 1)'(cols_eff);

  always_comb begin
    state_d    = state_q;
    rows_d     = rows_q;
    cols_d     = cols_q;
    fg_d       = fg_q;
    bg_d       = bg_q;
    font_d     = font_q;
    wp_d       = wp_q;
    rp_d       = rp_q;
    cnt_d      = cnt_q;
    div_cnt_d  = div_cnt_q;
    done_d     = 1'b0;
    char_out_d = 8'd0;
    ok_d       = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = wp_q;
    mem_wdata  = new_cell;
    mem_raddr  = rp_q;
    div_load   = 1'b0;
    div_dvd_in = DVW'(wp_q);
    div_dvs_in = DSW'(cols_eff);

    if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_ROWS: rows_d = cfg_data_i[6:0];
        CFG_COLS: cols_d = cfg_data_i;
        CFG_FG:   fg_d   = cfg_data_i;
        CFG_BG:   bg_d   = cfg_data_i;
        CFG_FONT: font_d = cfg_data_i;
        default: ;
      endcase
    end

    case (state_q)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_q;
        mem_wdata = '0;
        if (cnt_q == PW'(MAX_CELLS - 1)) begin
          cnt_d   = '0;
          state_d = S_IDLE;
        end else begin
          cnt_d = cnt_q + PW'(1);
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        case (op_q)
          OP_PUT: begin
            if (ch_q == ChBackspace) begin
              if (wp_q != rp_q) begin
                wp_d = (wp_q == '0) ? last_pos : wp_q - PW'(1);
              end
              done_d  = 1'b1;
              state_d = S_IDLE;
            end else begin
              mem_we = 1'b1;
              if (ch_q == ChNewline) begin
                div_load  = 1'b1;
                div_cnt_d = CNTW'(DVW);
                state_d   = S_DIV;
              end else begin
                wp_d    = (wp_inc >= total_q) ? '0 : PW'(wp_inc);
                done_d  = 1'b1;
                state_d = S_IDLE;
              end
            end
          end
          OP_GET: begin
            if (rp_q != wp_q) begin
              state_d = S_GET;
            end else begin
              done_d  = 1'b1;
              state_d = S_IDLE;
            end
          end
          OP_UNGET: begin
            mem_raddr = unget_pos;
            if (unget_pos != wp_q) begin
              rp_d    = unget_pos;
              state_d = S_UNGET;
            end else begin
              done_d  = 1'b1;
              state_d = S_IDLE;
            end
          end
          OP_FILL: begin
            cnt_d   = '0;
            state_d = S_FILL;
          end
          OP_CURSOR: begin
            div_load   = 1'b1;
            div_dvd_in = DVW'(cursor_lin);
            div_dvs_in = DSW'(total_q);
            div_cnt_d  = CNTW'(DVW);
            state_d    = S_DIV;
          end
          default: begin
            done_d  = 1'b1;
            state_d = S_IDLE;
          end
        endcase
      end
      S_GET: begin
        char_out_d = rdata_q[7:0];
        ok_d       = 1'b1;
        rp_d       = (rp_inc >= total_q) ? '0 : PW'(rp_inc);
        done_d     = 1'b1;
        state_d    = S_IDLE;
      end
      S_UNGET: begin
        mem_we     = 1'b1;
        mem_waddr  = rp_q;
        mem_wdata  = {rdata_q[CellW-1:8], ch_q};
        char_out_d = ch_q;
        ok_d       = 1'b1;
        done_d     = 1'b1;
        state_d    = S_IDLE;
      end
      S_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_q;
        if (cnt_q == last_pos) begin
          cnt_d   = '0;
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else begin
          cnt_d = cnt_q + PW'(1);
        end
      end
      S_DIV: begin
        div_cnt_d = div_cnt_q - CNTW'(1);
        if (div_cnt_q == CNTW'(1)) begin
          state_d = S_POST;
        end
      end
      S_POST: begin
        if (op_q == OP_PUT) begin
          wp_d = (lf_pos >= (DSW + 1)'(total_q)) ? '0 : PW'(lf_pos);
        end else begin
          wp_d = PW'(div_rem_q);
        end
        done_d  = 1'b1;
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    empty_d = (rp_d == wp_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLEAR;
      rows_q     <= RowsReset;
      cols_q     <= ColsReset;
      fg_q       <= FgReset;
      bg_q       <= BgReset;
      font_q     <= FontReset;
      wp_q       <= '0;
      rp_q       <= '0;
      cnt_q      <= '0;
      div_cnt_q  <= '0;
      done_q     <= 1'b0;
      char_out_q <= 8'd0;
      ok_q       <= 1'b0;
      empty_q    <= 1'b1;
    end else begin
      state_q    <= state_d;
      rows_q     <= rows_d;
      cols_q     <= cols_d;
      fg_q       <= fg_d;
      bg_q       <= bg_d;
      font_q     <= font_d;
      wp_q       <= wp_d;
      rp_q       <= rp_d;
      cnt_q      <= cnt_d;
      div_cnt_q  <= div_cnt_d;
      done_q     <= done_d;
      char_out_q <= char_out_d;
      ok_q       <= ok_d;
      empty_q    <= empty_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q    <= opcode_i;
      ch_q    <= char_in_i;
      row_q   <= cursor_row_i;
      col_q   <= cursor_col_i;
      total_q <= total_in;
    end
    if (div_load) begin
      div_rem_q <= '0;
      div_dvd_q <= div_dvd_in;
      div_dvs_q <= div_dvs_in;
    end else if (state_q == S_DIV) begin
      div_rem_q <= rem_nx;
      div_dvd_q <= {div_dvd_q[DVW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[mem_raddr];
  end

endmodule
